// ===== hdl/gbc_pkg.sv =====
// shared types and constants for the gyro bias calibrator
package gbc_pkg;

  localparam int COUNT_W   = 8;
  localparam int THR_W     = 15;
  localparam int MS_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 3;
  localparam int TIME_W    = 32;
  localparam int THR2_W    = 2 * THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_COUNT   = 2'd3;

  localparam logic [THR_W-1:0]   THR_RESET     = 15'd160;
  localparam logic [MS_W-1:0]    HOLD_RESET    = 16'd1000;
  localparam logic [MS_W-1:0]    TIMEOUT_RESET = 16'd10000;
  localparam logic [COUNT_W-1:0] ATTEMPT_RESET = 8'd100;

  typedef enum logic [STATUS_W-1:0] {
    PH_SEEK    = 3'd0,
    PH_COLLECT = 3'd1,
    PH_DONE    = 3'd2,
    PH_TIMEOUT = 3'd3,
    PH_NOGOOD  = 3'd4
  } gbc_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MAG,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } gbc_state_e;

  typedef struct packed {
    logic               load;
    logic               clear;
    logic               accum;
    logic               div_load;
    logic               div_step;
    logic [COUNT_W-1:0] divisor;
  } gbc_lane_ctrl_t;

endpackage

// ===== hdl/gyro_bias_calibrator.sv =====
// top level of the gyro zero-rate bias calibrator
// An accepted sample request blocks the next one while it passes a capture step, a step for
// the lane squarers, one for the magnitude compare in the merge stage, one for the phase update
// and one to load the result register, which waits while the held result is stalled. The sample
// that ends the collecting phase with good samples also passes a divider load state and the
// divide state, in which the three bit-serial lane dividers form sum / count one quotient bit
// per cycle. A finished result waits in the output register while the next sample is processed.
module gyro_bias_calibrator #(
  parameter int RATE_WIDTH   = 16,
  parameter int MAX_ATTEMPTS = 255
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 sample_ok_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_x_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_y_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_z_i,
  input  logic [gbc_pkg::TIME_W-1:0]           time_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gbc_pkg::STATUS_W-1:0]         cal_status_o,
  output logic signed [RATE_WIDTH-1:0]         offset_x_o,
  output logic signed [RATE_WIDTH-1:0]         offset_y_o,
  output logic signed [RATE_WIDTH-1:0]         offset_z_o,
  input  logic                                 cfg_we_i,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gbc_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int CW        = gbc_pkg::COUNT_W;
  localparam int SUM_W     = RATE_WIDTH + CW;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam logic [CW-1:0]        MAX_ATT  = CW'(MAX_ATTEMPTS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  gbc_pkg::gbc_state_e state_q, state_d;
  gbc_pkg::gbc_phase_e phase_q, phase_d;
  gbc_pkg::gbc_lane_ctrl_t lane_ctrl;

  logic [gbc_pkg::THR_W-1:0]  thr_q;
  logic [gbc_pkg::MS_W-1:0]   hold_q;
  logic [gbc_pkg::MS_W-1:0]   timeout_q;
  logic [CW-1:0]              att_cfg_q;

  logic                       started_q, started_d;
  logic                       was_still_q, was_still_d;
  logic [gbc_pkg::TIME_W-1:0] start_time_q, start_time_d;
  logic [gbc_pkg::TIME_W-1:0] still_since_q, still_since_d;
  logic [CW-1:0]              attempts_q, attempts_d;
  logic [CW-1:0]              good_q, good_d;
  logic [DIV_CNT_W-1:0]       div_cnt_q, div_cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       res_load;

  logic                       ok_q;
  logic [gbc_pkg::TIME_W-1:0] now_q;
  logic                       accept;
  logic                       still;
  logic [gbc_pkg::TIME_W-1:0] elapsed;
  logic [gbc_pkg::TIME_W-1:0] still_elapsed;
  logic [CW-1:0]              limit;
  logic [CW-1:0]              att_inc;
  logic [CW-1:0]              good_inc;

  logic signed [RATE_WIDTH-1:0] lane_rate [3];
  logic [2*RATE_WIDTH-1:0]      lane_sq   [3];
  logic signed [RATE_WIDTH-1:0] lane_off  [3];
  logic [gbc_pkg::STATUS_W-1:0] status_q;
  logic signed [RATE_WIDTH-1:0] off_q     [3];

  assign lane_rate[0] = rate_x_i;
  assign lane_rate[1] = rate_y_i;
  assign lane_rate[2] = rate_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    gbc_lane #(
      .RATE_WIDTH(RATE_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .rate_i  (lane_rate[g]),
      .square_o(lane_sq[g]),
      .offset_o(lane_off[g])
    );
  end

  gbc_merge #(
    .RATE_WIDTH(RATE_WIDTH)
  ) u_merge (
    .clk_i      (clk_i),
    .square_x_i (lane_sq[0]),
    .square_y_i (lane_sq[1]),
    .square_z_i (lane_sq[2]),
    .threshold_i(thr_q),
    .still_o    (still)
  );

  assign in_stall_o    = state_q != gbc_pkg::ST_IDLE;
  assign accept        = in_valid_i && !in_stall_o;
  assign elapsed       = started_q ? now_q - start_time_q : '0;
  assign still_elapsed = now_q - still_since_q;
  assign att_inc       = CW'(attempts_q + 1'b1);
  assign good_inc      = CW'(good_q + CW'(ok_q));

  always_comb begin
    if (att_cfg_q == '0) begin
      limit = CW'(1);
    end else if (att_cfg_q > MAX_ATT) begin
      limit = MAX_ATT;
    end else begin
      limit = att_cfg_q;
    end
  end

  always_comb begin
    state_d            = state_q;
    phase_d            = phase_q;
    started_d          = started_q;
    was_still_d        = was_still_q;
    start_time_d       = start_time_q;
    still_since_d      = still_since_q;
    attempts_d         = attempts_q;
    good_d             = good_q;
    div_cnt_d          = div_cnt_q;
    out_valid_d        = out_valid_q && out_stall_i;
    res_load           = 1'b0;
    lane_ctrl          = '0;
    lane_ctrl.load     = accept;
    lane_ctrl.divisor  = good_q;
    case (state_q)
      gbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gbc_pkg::ST_SQUARE;
        end
      end
      gbc_pkg::ST_SQUARE: begin
        state_d = gbc_pkg::ST_MAG;
      end
      gbc_pkg::ST_MAG: begin
        state_d = gbc_pkg::ST_UPDATE;
      end
      gbc_pkg::ST_UPDATE: begin
        state_d = gbc_pkg::ST_OUT;
        case (phase_q)
          gbc_pkg::PH_SEEK: begin
            started_d = 1'b1;
            if (!started_q) begin
              start_time_d = now_q;
            end
            if (elapsed >= gbc_pkg::TIME_W'(timeout_q)) begin
              phase_d = gbc_pkg::PH_TIMEOUT;
            end else if (ok_q) begin
              if (still) begin
                if (!was_still_q) begin
                  still_since_d = now_q;
                  was_still_d   = 1'b1;
                end else if (still_elapsed >= gbc_pkg::TIME_W'(hold_q)) begin
                  phase_d         = gbc_pkg::PH_COLLECT;
                  attempts_d      = '0;
                  good_d          = '0;
                  lane_ctrl.clear = 1'b1;
                end
              end else begin
                was_still_d = 1'b0;
              end
            end
          end
          gbc_pkg::PH_COLLECT: begin
            lane_ctrl.accum = ok_q;
            good_d          = good_inc;
            attempts_d      = att_inc;
            if (att_inc >= limit) begin
              if (good_inc != '0) begin
                phase_d = gbc_pkg::PH_DONE;
                state_d = gbc_pkg::ST_DIV_LOAD;
              end else begin
                phase_d = gbc_pkg::PH_NOGOOD;
              end
            end
          end
          default: ;
        endcase
      end
      gbc_pkg::ST_DIV_LOAD: begin
        lane_ctrl.div_load = 1'b1;
        div_cnt_d          = '0;
        state_d            = gbc_pkg::ST_DIV;
      end
      gbc_pkg::ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        div_cnt_d          = DIV_CNT_W'(div_cnt_q + 1'b1);
        if (div_cnt_q == DIV_LAST) begin
          state_d = gbc_pkg::ST_OUT;
        end
      end
      gbc_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_load    = 1'b1;
          state_d     = gbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbc_pkg::ST_IDLE;
      phase_q     <= gbc_pkg::PH_SEEK;
      started_q   <= 1'b0;
      was_still_q <= 1'b0;
      attempts_q  <= '0;
      good_q      <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= gbc_pkg::THR_RESET;
      hold_q      <= gbc_pkg::HOLD_RESET;
      timeout_q   <= gbc_pkg::TIMEOUT_RESET;
      att_cfg_q   <= gbc_pkg::ATTEMPT_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      started_q   <= started_d;
      was_still_q <= was_still_d;
      attempts_q  <= attempts_d;
      good_q      <= good_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          gbc_pkg::REG_STILL_THRESHOLD: thr_q     <= cfg_data_i[gbc_pkg::THR_W-1:0];
          gbc_pkg::REG_HOLD_TIME:       hold_q    <= cfg_data_i[gbc_pkg::MS_W-1:0];
          gbc_pkg::REG_TIMEOUT:         timeout_q <= cfg_data_i[gbc_pkg::MS_W-1:0];
          gbc_pkg::REG_ATTEMPT_COUNT:   att_cfg_q <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_time_q  <= start_time_d;
    still_since_q <= still_since_d;
    if (accept) begin
      ok_q  <= sample_ok_i;
      now_q <= time_ms_i;
    end
    if (res_load) begin
      status_q <= phase_q;
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= (phase_q == gbc_pkg::PH_DONE) ? lane_off[i] : '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cal_status_o = status_q;
  assign offset_x_o   = off_q[0];
  assign offset_y_o   = off_q[1];
  assign offset_z_o   = off_q[2];

endmodule

// ===== hdl/gbc_lane.sv =====
// one axis lane: rate capture, square, running sum and bit-serial divider
module gbc_lane #(
  parameter int RATE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  gbc_pkg::gbc_lane_ctrl_t        ctrl_i,
  input  logic signed [RATE_WIDTH-1:0]   rate_i,
  output logic [2*RATE_WIDTH-1:0]        square_o,
  output logic signed [RATE_WIDTH-1:0]   offset_o
);

  localparam int SUM_W = RATE_WIDTH + gbc_pkg::COUNT_W;
  localparam int CW    = gbc_pkg::COUNT_W;

  logic signed [RATE_WIDTH-1:0]   rate_q;
  logic signed [2*RATE_WIDTH-1:0] prod;
  logic [2*RATE_WIDTH-1:0]        square_q;
  logic signed [SUM_W-1:0]        sum_q, sum_d;
  logic [SUM_W-1:0]               dvd_q, dvd_d;
  logic [CW-1:0]                  rem_q, rem_d;
  logic                           neg_q, neg_d;
  logic [CW:0]                    shifted;
  logic [CW:0]                    trial;
  logic [RATE_WIDTH-1:0]          quot;

  assign prod = rate_q * rate_q;

  always_comb begin
    sum_d   = sum_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    shifted = {rem_q, dvd_q[SUM_W-1]};
    trial   = shifted - {1'b0, ctrl_i.divisor};
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.accum) begin
      sum_d = sum_q + {{(SUM_W-RATE_WIDTH){rate_q[RATE_WIDTH-1]}}, rate_q};
    end
    if (ctrl_i.div_load) begin
      neg_d = sum_q[SUM_W-1];
      dvd_d = sum_q[SUM_W-1] ? -sum_q : sum_q;
      rem_d = '0;
    end else if (ctrl_i.div_step) begin
      if (!trial[CW]) begin
        rem_d = trial[CW-1:0];
        dvd_d = {dvd_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[CW-1:0];
        dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rate_q <= rate_i;
    end
    square_q <= prod;
    sum_q    <= sum_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
  end

  assign quot     = dvd_q[RATE_WIDTH-1:0];
  assign square_o = square_q;
  assign offset_o = neg_q ? -quot : quot;

endmodule

// ===== hdl/gbc_merge.sv =====
// merges the lane squares into a magnitude and compares with the squared threshold
module gbc_merge #(
  parameter int RATE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic [2*RATE_WIDTH-1:0]       square_x_i,
  input  logic [2*RATE_WIDTH-1:0]       square_y_i,
  input  logic [2*RATE_WIDTH-1:0]       square_z_i,
  input  logic [gbc_pkg::THR_W-1:0]     threshold_i,
  output logic                          still_o
);

  localparam int MAG_W = 2 * RATE_WIDTH + 2;
  localparam int CMP_W = (MAG_W > gbc_pkg::THR2_W) ? MAG_W : gbc_pkg::THR2_W;

  logic [gbc_pkg::THR2_W-1:0] thr2_q;
  logic [CMP_W-1:0]           mag;
  logic                       still_q;

  assign mag = CMP_W'(square_x_i) + CMP_W'(square_y_i) + CMP_W'(square_z_i);

  always_ff @(posedge clk_i) begin
    thr2_q  <= threshold_i * threshold_i;
    still_q <= mag < CMP_W'(thr2_q);
  end

  assign still_o = still_q;

endmodule

// ===== hdl/gbc_checker.sv =====
// port-level checker for the gyro bias calibrator and its bind
module gbc_checker #(
  parameter int RATE_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [gbc_pkg::STATUS_W-1:0]  cal_status_o,
  input logic signed [RATE_WIDTH-1:0]  offset_x_o,
  input logic signed [RATE_WIDTH-1:0]  offset_y_o,
  input logic signed [RATE_WIDTH-1:0]  offset_z_o
);

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is still in flight");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cal_status_o <= 3'd4)
    else $error("status code out of range");

  // offsets only carry a value once calibrated
  a_offsets_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cal_status_o != gbc_pkg::PH_DONE |->
      offset_x_o == '0 && offset_y_o == '0 && offset_z_o == '0)
    else $error("nonzero offset without calibration");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cal_status_o) &&
      $stable(offset_x_o) && $stable(offset_y_o) && $stable(offset_z_o))
    else $error("stalled result changed");

endmodule

bind gyro_bias_calibrator gbc_checker #(
  .RATE_WIDTH(RATE_WIDTH)
) u_gbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cal_status_o(cal_status_o),
  .offset_x_o  (offset_x_o),
  .offset_y_o  (offset_y_o),
  .offset_z_o  (offset_z_o)
);
